/* rtl/core/dcc_pkg.sv */
// Package for the DCC command frame builder: command codes, frame constants and frame helpers.
`default_nettype none

package dcc_pkg;

   localparam int FRAME_W = 51;
   localparam int ADDR_W  = 8;
   localparam int DATA_W  = 32;
   localparam int PADDR_W = 3;

   typedef enum logic [2:0] {
      ACT_FORWARD = 3'd0,
      ACT_REVERSE = 3'd1,
      ACT_TOGGLE  = 3'd2,
      ACT_RESET   = 3'd3,
      ACT_RESEND  = 3'd4
   } action_type;

   // Register index of the decoder address.
   localparam logic [PADDR_W-3:0] REG_LOCO_ADDRESS = 1'b0;

   localparam logic [ADDR_W-1:0]  LOCO_ADDRESS_RESET = 8'd1;
   localparam logic [FRAME_W-1:0] LAST_FRAME_RESET   = 51'd1;

   localparam logic [22:0] LONG_PREAMBLE  = 23'h7FFFFF;
   localparam logic [13:0] SHORT_PREAMBLE = 14'h3FFF;
   localparam logic [FRAME_W-1:0] RESET_FRAME = {19'h7FFFF, 32'hF0000001};

   localparam logic [7:0] SPEED_FWD_LEAD = 8'h60;
   localparam logic [7:0] SPEED_REV_LEAD = 8'h40;
   localparam logic [7:0] GROUP_ONE_LEAD = 8'h80;
   localparam logic [7:0] GROUP_TWO_LOW_LEAD  = 8'hB0;
   localparam logic [7:0] GROUP_TWO_HIGH_LEAD = 8'hA0;
   localparam logic [7:0] EXPANSION_LEAD = 8'hDE;

   localparam logic [4:0] FN_LAST = 5'd20;

   // Address, one data byte and check byte behind a 23-bit preamble.
   function automatic logic [FRAME_W-1:0] build_three(input logic [7:0] adr,
                                                     input logic [7:0] data);
      logic [7:0] chk;
      chk = adr ^ data;
      return {LONG_PREAMBLE, 1'b0, adr, 1'b0, data, 1'b0, chk, 1'b1};
   endfunction

   // Address, two data bytes and check byte behind a 14-bit preamble.
   function automatic logic [FRAME_W-1:0] build_four(input logic [7:0] adr,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2);
      logic [7:0] chk;
      chk = adr ^ b1 ^ b2;
      return {SHORT_PREAMBLE, 1'b0, adr, 1'b0, b1, 1'b0, b2, 1'b0, chk, 1'b1};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/dcc_command_frame_builder.sv */
// Top level of the DCC command frame builder.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  action, speed_step, function_index
//   rsp      out        rsp_valid / rsp_stall  frame_bits, bad_request
//   csr      in/out     APB psel / penable     loco_address at byte address 0
//
// An accepted command waits in the input register until the result register can take it,
// and its result word is registered there before it leaves on the result side.
// One command is accepted every cycle while the result side keeps up. Function state
// and the last frame are updated when a command leaves the input register, so the next
// command sees them at once.
// The input stalls only when both registers are full and the result side stalls.
// Synchronous reset clears all valid bits and function state, and sets the last frame to 1.
`default_nettype none

module dcc_command_frame_builder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [2:0]                   req_action,
   input  wire logic [4:0]                   req_speed_step,
   input  wire logic [4:0]                   req_function_index,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [dcc_pkg::FRAME_W-1:0]       rsp_frame_bits,
   output logic                              rsp_bad_request,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [dcc_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [dcc_pkg::DATA_W-1:0]   pwdata,
   output logic [dcc_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   logic [dcc_pkg::ADDR_W-1:0]  loco_address_ff;
   logic                        s1_valid_ff;
   logic [2:0]                  s1_action_ff;
   logic [4:0]                  s1_speed_step_ff;
   logic [4:0]                  s1_function_index_ff;
   logic                        rsp_valid_ff;
   logic [dcc_pkg::FRAME_W-1:0] rsp_frame_ff;
   logic                        rsp_bad_ff;

   logic [4:0]                  group_one_ff, group_one_in;
   logic [3:0]                  group_two_low_ff, group_two_low_in;
   logic [3:0]                  group_two_high_ff, group_two_high_in;
   logic [7:0]                  expansion_ff, expansion_in;
   logic [dcc_pkg::FRAME_W-1:0] last_frame_ff, last_frame_in;
   logic                        bad_in;

   logic advance;
   logic req_accept;
   logic csr_write;
   logic csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[dcc_pkg::PADDR_W-1:2] == dcc_pkg::REG_LOCO_ADDRESS);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? {{(dcc_pkg::DATA_W-dcc_pkg::ADDR_W){1'b0}}, loco_address_ff}
                              : '0;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_bits  = rsp_frame_ff;
   assign rsp_bad_request = rsp_bad_ff;

   always_comb begin
      logic [7:0] speed_data;
      logic [4:0] fn;
      fn               = s1_function_index_ff;
      speed_data       = '0;
      group_one_in     = group_one_ff;
      group_two_low_in = group_two_low_ff;
      group_two_high_in = group_two_high_ff;
      expansion_in     = expansion_ff;
      last_frame_in    = last_frame_ff;
      bad_in           = 1'b0;
      case (s1_action_ff)
         dcc_pkg::ACT_FORWARD, dcc_pkg::ACT_REVERSE: begin
            speed_data = ((s1_action_ff == dcc_pkg::ACT_FORWARD) ? dcc_pkg::SPEED_FWD_LEAD
                                                                : dcc_pkg::SPEED_REV_LEAD)
                       | {3'b000, s1_speed_step_ff[0], s1_speed_step_ff[4:1]};
            last_frame_in = dcc_pkg::build_three(loco_address_ff, speed_data);
         end
         dcc_pkg::ACT_TOGGLE: begin
            case (fn) inside
               [5'd0:5'd4]: begin
                  // F0 sits above F4..F1 in the group byte.
                  if (fn == 5'd0) begin
                     group_one_in = group_one_ff ^ 5'b10000;
                  end else begin
                     group_one_in = group_one_ff ^ (5'd1 << (fn - 5'd1));
                  end
                  last_frame_in = dcc_pkg::build_three(loco_address_ff,
                                     dcc_pkg::GROUP_ONE_LEAD | {3'b000, group_one_in});
               end
               [5'd5:5'd8]: begin
                  group_two_low_in = group_two_low_ff ^ (4'd1 << (fn - 5'd5));
                  last_frame_in = dcc_pkg::build_three(loco_address_ff,
                                     dcc_pkg::GROUP_TWO_LOW_LEAD | {4'h0, group_two_low_in});
               end
               [5'd9:5'd12]: begin
                  group_two_high_in = group_two_high_ff ^ (4'd1 << (fn - 5'd9));
                  last_frame_in = dcc_pkg::build_three(loco_address_ff,
                                     dcc_pkg::GROUP_TWO_HIGH_LEAD | {4'h0, group_two_high_in});
               end
               [5'd13:dcc_pkg::FN_LAST]: begin
                  expansion_in = expansion_ff ^ (8'd1 << (fn - 5'd13));
                  last_frame_in = dcc_pkg::build_four(loco_address_ff,
                                     dcc_pkg::EXPANSION_LEAD, expansion_in);
               end
               default: begin
                  // Unknown function: keep state and resend the last frame.
                  bad_in = 1'b1;
               end
            endcase
         end
         dcc_pkg::ACT_RESET: begin
            last_frame_in = dcc_pkg::RESET_FRAME;
         end
         default: begin
            last_frame_in = last_frame_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loco_address_ff <= dcc_pkg::LOCO_ADDRESS_RESET;
      end else if (csr_write) begin
         loco_address_ff <= pwdata[dcc_pkg::ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff         <= req_action;
         s1_speed_step_ff     <= req_speed_step;
         s1_function_index_ff <= req_function_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         group_one_ff      <= '0;
         group_two_low_ff  <= '0;
         group_two_high_ff <= '0;
         expansion_ff      <= '0;
         last_frame_ff     <= dcc_pkg::LAST_FRAME_RESET;
      end else begin
         if (advance) begin
            rsp_valid_ff      <= 1'b1;
            group_one_ff      <= group_one_in;
            group_two_low_ff  <= group_two_low_in;
            group_two_high_ff <= group_two_high_in;
            expansion_ff      <= expansion_in;
            last_frame_ff     <= last_frame_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_frame_ff <= last_frame_in;
         rsp_bad_ff   <= bad_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dcc_frame_chk.sv */
// Port-level checker for the DCC command frame builder and its bind.
`default_nettype none

module dcc_frame_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [dcc_pkg::FRAME_W-1:0] rsp_frame_bits,
   input wire logic                        rsp_bad_request
);

   // Reset leaves no result word pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // Every frame, including the reset value of the stored frame, ends in the end bit.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> rsp_frame_bits[0])
      else $error("frame without end bit");

   // The input only backs up when the result side is full and stalled.
   assert property (@(posedge clock) disable iff (reset)
                    req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result side free");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_stall) |=>
                    (rsp_valid && $stable(rsp_frame_bits) && $stable(rsp_bad_request)))
      else $error("stalled result word changed");

endmodule

bind dcc_command_frame_builder dcc_frame_chk u_dcc_frame_chk (.*);

`default_nettype wire
